[rtl/fade_envelope_idle_timer_defines.svh]
// Assertion macros shared by the fade envelope idle timer RTL.
`ifndef FADE_ENVELOPE_IDLE_TIMER_DEFINES_SVH
`define FADE_ENVELOPE_IDLE_TIMER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define FET_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("fade envelope idle timer: check failed");

// Next-cycle implication, disabled during reset.
`define FET_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("fade envelope idle timer: check failed");

`endif

[rtl/fet_pkg.sv]
// Types and constants for the fade envelope idle timer.
`default_nettype none
package fet_pkg;

    localparam int FADE_W    = 16;
    localparam int PEAK_W    = 8;
    localparam int CFG_W     = 32;
    localparam int ADDR_W    = 4;
    localparam int NUM_W     = FADE_W + PEAK_W;
    localparam int REM_W     = FADE_W;
    localparam int DIV_STEPS = NUM_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // Register indexes (word address bits)
    localparam logic [1:0] REG_FADE_TIME    = 2'd0;
    localparam logic [1:0] REG_CYCLE_LENGTH = 2'd1;
    localparam logic [1:0] REG_IDLE_LIMIT   = 2'd2;
    localparam logic [1:0] REG_VOLUME_PEAK  = 2'd3;

    // Request codes
    localparam logic REQ_ENTER = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    localparam logic [FADE_W-1:0] RST_FADE_TIME    = 16'd2000;
    localparam logic [CFG_W-1:0]  RST_CYCLE_LENGTH = 32'd60000;
    localparam logic [CFG_W-1:0]  RST_IDLE_LIMIT   = 32'd30000;
    localparam logic [PEAK_W-1:0] RST_VOLUME_PEAK  = 8'd7;

    typedef struct packed {
        logic [FADE_W-1:0] fade_time;
        logic [CFG_W-1:0]  cycle_length;
        logic [CFG_W-1:0]  idle_limit;
        logic [PEAK_W-1:0] volume_peak;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_IDLE_SUB,
        ST_IDLE_CMP,
        ST_MUS_SUB,
        ST_MUS_CMP,
        ST_FADE_CMP,
        ST_CYC_CMP,
        ST_REST_SUB,
        ST_REST_CMP,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

[rtl/fet_cfg.sv]
// APB configuration registers of the fade envelope idle timer.
`default_nettype none
module fet_cfg import fet_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [CFG_W-1:0]  pwdata,
    output logic      [CFG_W-1:0]  prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    // Write registers on the access cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.fade_time    <= RST_FADE_TIME;
            cfg_reg.cycle_length <= RST_CYCLE_LENGTH;
            cfg_reg.idle_limit   <= RST_IDLE_LIMIT;
            cfg_reg.volume_peak  <= RST_VOLUME_PEAK;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                REG_FADE_TIME:    cfg_reg.fade_time    <= pwdata[FADE_W-1:0];
                REG_CYCLE_LENGTH: cfg_reg.cycle_length <= pwdata;
                REG_IDLE_LIMIT:   cfg_reg.idle_limit   <= pwdata;
                REG_VOLUME_PEAK:  cfg_reg.volume_peak  <= pwdata[PEAK_W-1:0];
                default:          cfg_reg.volume_peak  <= cfg_reg.volume_peak;
            endcase
        end
    end

    // Return the addressed register
    always_comb begin
        unique case (paddr[3:2])
            REG_FADE_TIME:    prdata = CFG_W'(cfg_reg.fade_time);
            REG_CYCLE_LENGTH: prdata = cfg_reg.cycle_length;
            REG_IDLE_LIMIT:   prdata = cfg_reg.idle_limit;
            REG_VOLUME_PEAK:  prdata = CFG_W'(cfg_reg.volume_peak);
            default:          prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

[rtl/fet_sub.sv]
// Shared subtractor with borrow, used for elapsed times, compares and division steps.
`default_nettype none
module fet_sub #(
    parameter int W = 32
) (
    input  wire logic [W-1:0] a,
    input  wire logic [W-1:0] b,
    output logic      [W-1:0] diff,
    output logic              borrow
);

    logic [W:0] full;

    // Borrow out is the extra top bit of the widened difference
    assign full   = {1'b0, a} - {1'b0, b};
    assign diff   = full[W-1:0];
    assign borrow = full[W];

endmodule
`default_nettype wire

[rtl/fet_core.sv]
// Sequencer and datapath: stamps, idle and cycle checks, envelope and serial divide.
`default_nettype none
`include "fade_envelope_idle_timer_defines.svh"
module fet_core import fet_pkg::*; #(
    parameter int TIME_WIDTH = 32
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire logic         s_req_type,
    input  wire logic [31:0]  s_now_time,
    input  wire logic         s_user_activity,
    output logic              m_valid,
    input  wire logic         m_ready,
    output logic              m_restart,
    output logic              m_attract,
    output logic [PEAK_W-1:0] m_volume,
    input  wire cfg_t         cfg,
    output logic [((TIME_WIDTH > CFG_W) ? TIME_WIDTH : CFG_W)-1:0] sub_a,
    output logic [((TIME_WIDTH > CFG_W) ? TIME_WIDTH : CFG_W)-1:0] sub_b,
    input  wire logic [((TIME_WIDTH > CFG_W) ? TIME_WIDTH : CFG_W)-1:0] sub_diff,
    input  wire logic         sub_borrow
);

    localparam int SW = (TIME_WIDTH > CFG_W) ? TIME_WIDTH : CFG_W;

    state_t state_reg, state_next;

    logic [TIME_WIDTH-1:0] now_reg;
    logic [TIME_WIDTH-1:0] music_stamp_reg;
    logic [TIME_WIDTH-1:0] idle_stamp_reg;
    logic [TIME_WIDTH-1:0] elap_reg;
    logic [CFG_W-1:0]      rest_reg;
    logic [FADE_W-1:0]     t_reg;
    logic [NUM_W-1:0]      num_reg;
    logic [REM_W-1:0]      rem_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  restart_reg;
    logic                  attract_reg;
    logic [PEAK_W-1:0]     vol_reg;
    logic                  m_valid_reg;
    logic                  m_restart_reg;
    logic                  m_attract_reg;
    logic [PEAK_W-1:0]     m_volume_reg;

    logic [TIME_WIDTH-1:0] now_in;
    logic [REM_W:0]        trial;
    logic                  in_fire;
    logic                  out_free;
    logic                  div_last;

    assign now_in   = TIME_WIDTH'(s_now_time);
    assign trial    = {rem_reg, num_reg[NUM_W-1]};
    assign in_fire  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign div_last = (cnt_reg == CNT_W'(DIV_STEPS - 1));

    assign m_valid   = m_valid_reg;
    assign m_restart = m_restart_reg;
    assign m_attract = m_attract_reg;
    assign m_volume  = m_volume_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (in_fire && (s_req_type == REQ_TICK)) state_next = ST_IDLE_SUB;
            ST_IDLE_SUB: state_next = ST_IDLE_CMP;
            ST_IDLE_CMP: state_next = ST_MUS_SUB;
            ST_MUS_SUB:  state_next = ST_MUS_CMP;
            ST_MUS_CMP:  state_next = ST_FADE_CMP;
            ST_FADE_CMP: state_next = sub_borrow ? ST_MUL : ST_CYC_CMP;
            ST_CYC_CMP:  state_next = sub_borrow ? ST_REST_SUB : ST_DONE;
            ST_REST_SUB: state_next = ST_REST_CMP;
            ST_REST_CMP: state_next = sub_borrow ? ST_MUL : ST_DONE;
            ST_MUL:      state_next = ST_DIV;
            ST_DIV:      if (div_last) state_next = ST_DONE;
            ST_DONE:     if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Outputs: ready and shared subtractor operands
    always_comb begin
        s_ready = (state_reg == ST_IDLE);
        sub_a   = '0;
        sub_b   = '0;
        unique case (state_reg)
            ST_IDLE_SUB: begin
                sub_a = SW'(now_reg);
                sub_b = SW'(idle_stamp_reg);
            end
            ST_IDLE_CMP: begin
                sub_a = SW'(elap_reg);
                sub_b = SW'(cfg.idle_limit);
            end
            ST_MUS_SUB: begin
                sub_a = SW'(now_reg);
                sub_b = SW'(music_stamp_reg);
            end
            ST_MUS_CMP, ST_CYC_CMP: begin
                sub_a = SW'(elap_reg);
                sub_b = SW'(cfg.cycle_length);
            end
            ST_FADE_CMP: begin
                sub_a = SW'(elap_reg);
                sub_b = SW'(cfg.fade_time);
            end
            ST_REST_SUB: begin
                sub_a = SW'(cfg.cycle_length);
                sub_b = SW'(elap_reg);
            end
            ST_REST_CMP: begin
                sub_a = SW'(rest_reg);
                sub_b = SW'(cfg.fade_time);
            end
            ST_DIV: begin
                sub_a = SW'(trial);
                sub_b = SW'(cfg.fade_time);
            end
            default: begin
                sub_a = '0;
                sub_b = '0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            m_valid_reg     <= 1'b0;
            music_stamp_reg <= '0;
            idle_stamp_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            // Load stamps on enter, restart idle stamp on activity
            if (in_fire) begin
                if (s_req_type == REQ_ENTER) begin
                    music_stamp_reg <= now_in;
                    idle_stamp_reg  <= now_in;
                end else if (s_user_activity) begin
                    idle_stamp_reg  <= now_in;
                end
            end
            // Restart music cycle once elapsed time reaches the cycle length
            if (state_reg == ST_MUS_CMP && !sub_borrow) begin
                music_stamp_reg <= now_reg;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    now_reg     <= now_in;
                    restart_reg <= 1'b0;
                end
            end
            ST_IDLE_SUB: elap_reg <= sub_diff[TIME_WIDTH-1:0];
            ST_IDLE_CMP: attract_reg <= !sub_borrow;
            ST_MUS_SUB:  elap_reg <= sub_diff[TIME_WIDTH-1:0];
            ST_MUS_CMP: begin
                if (!sub_borrow) begin
                    restart_reg <= 1'b1;
                    elap_reg    <= '0;
                end
            end
            ST_FADE_CMP: t_reg <= elap_reg[FADE_W-1:0];
            ST_CYC_CMP:  vol_reg <= '0;
            ST_REST_SUB: rest_reg <= sub_diff[CFG_W-1:0];
            ST_REST_CMP: begin
                t_reg   <= rest_reg[FADE_W-1:0];
                vol_reg <= cfg.volume_peak;
            end
            ST_MUL: begin
                num_reg <= NUM_W'(t_reg) * NUM_W'(cfg.volume_peak);
                rem_reg <= '0;
                cnt_reg <= '0;
            end
            // One restoring division step: quotient bits shift into num_reg
            ST_DIV: begin
                rem_reg <= sub_borrow ? trial[REM_W-1:0] : sub_diff[REM_W-1:0];
                num_reg <= {num_reg[NUM_W-2:0], !sub_borrow};
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (div_last) begin
                    vol_reg <= {num_reg[PEAK_W-2:0], !sub_borrow};
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_restart_reg <= restart_reg;
                    m_attract_reg <= attract_reg;
                    m_volume_reg  <= vol_reg;
                end
            end
            default: begin
                vol_reg <= vol_reg;
            end
        endcase
    end

    `FET_ASSERT_NEXT(a_enter_no_work, aclk, aresetn, in_fire && (s_req_type == REQ_ENTER), state_reg == ST_IDLE)
    `FET_ASSERT_NEXT(a_tick_starts, aclk, aresetn, in_fire && (s_req_type == REQ_TICK), state_reg == ST_IDLE_SUB)
    `FET_ASSERT_IMPL(a_vol_peak, aclk, aresetn, m_valid_reg, m_volume_reg <= cfg.volume_peak)
    `FET_ASSERT_IMPL(a_restart_silent, aclk, aresetn, m_valid_reg && m_restart_reg && (cfg.fade_time != '0), m_volume_reg == '0)

endmodule
`default_nettype wire

[rtl/fade_envelope_idle_timer.sv]
// Top level of the fade envelope idle timer.
//
//   channel  direction  handshake              payload
//   s_       in         s_valid / s_ready      s_req_type, s_now_time, s_user_activity
//   m_       out        m_valid / m_ready      m_restart, m_attract, m_volume
//   apb      in         psel, penable, pready  paddr, pwdata, prdata
//
// An enter transaction only loads the stamps and gives no result.
// A tick transaction makes five checks through the shared subtractor, up to three more
// for the fade-out, then, when fading in or out, one multiply and 24 restoring divide steps.
// The 24-step divide on the shared subtractor sets the worst case.
// s_ready is high only while the sequencer is idle; a finished result waits in the
// output register, and the next transaction is taken while it waits.
// aresetn is synchronous, active low; it restores register defaults and clears both stamps.
`default_nettype none
module fade_envelope_idle_timer import fet_pkg::*; #(
    parameter int TIME_WIDTH = 32
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic              s_req_type,
    input  wire logic [31:0]       s_now_time,
    input  wire logic              s_user_activity,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic                   m_restart,
    output logic                   m_attract,
    output logic [PEAK_W-1:0]      m_volume,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [CFG_W-1:0]  pwdata,
    output logic      [CFG_W-1:0]  prdata,
    output logic                   pready
);

    localparam int SW = (TIME_WIDTH > CFG_W) ? TIME_WIDTH : CFG_W;

    cfg_t          cfg;
    logic [SW-1:0] sub_a;
    logic [SW-1:0] sub_b;
    logic [SW-1:0] sub_diff;
    logic          sub_borrow;

    // Register block
    fet_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Shared subtract unit
    fet_sub #(.W(SW)) u_sub (
        .a      (sub_a),
        .b      (sub_b),
        .diff   (sub_diff),
        .borrow (sub_borrow)
    );

    // Sequencer and datapath
    fet_core #(.TIME_WIDTH(TIME_WIDTH)) u_core (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_now_time      (s_now_time),
        .s_user_activity (s_user_activity),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_restart       (m_restart),
        .m_attract       (m_attract),
        .m_volume        (m_volume),
        .cfg             (cfg),
        .sub_a           (sub_a),
        .sub_b           (sub_b),
        .sub_diff        (sub_diff),
        .sub_borrow      (sub_borrow)
    );

endmodule
`default_nettype wire

[bench/fade_envelope_idle_timer_test.sv]
// Self-checking testbench for the fade envelope idle timer: directed table, then random phases.
module fade_envelope_idle_timer_test;
    timeunit 1ns;
    timeprecision 1ps;
    import fet_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 8;
    localparam int SETTLE_CYCLES = 48;
    localparam int HOLD_OFF      = 400;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 100;
    localparam int PRINT_CAP     = 100;

    typedef struct packed {
        logic              restart;
        logic              attract;
        logic [PEAK_W-1:0] volume;
    } envelope_out_t;

    typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

    // One directed step: a transaction, or a register write (reg_idx, value)
    typedef struct {
        row_kind_t     kind;
        logic [1:0]    reg_idx;
        logic [31:0]   value;
        logic          req;
        logic          act;
        bit            typed;
        envelope_out_t want;
    } plan_row_t;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic              s_req_type;
    logic [31:0]       s_now_time;
    logic              s_user_activity;
    logic              m_valid;
    logic              m_ready;
    logic              m_restart;
    logic              m_attract;
    logic [PEAK_W-1:0] m_volume;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [CFG_W-1:0]  pwdata;
    logic [CFG_W-1:0]  prdata;
    logic              pready;

    // Tracked configuration and stamps
    logic [FADE_W-1:0] fade_ms;
    logic [CFG_W-1:0]  cycle_ms;
    logic [CFG_W-1:0]  idle_limit_ms;
    logic [PEAK_W-1:0] peak_level;
    logic [31:0]       music_stamp_ms;
    logic [31:0]       idle_stamp_ms;

    envelope_out_t     envelope_due[$];
    int unsigned       mismatches = 0;
    int unsigned       cycle_count = 0;
    int                tx_idle_pct;
    int                rx_idle_pct;
    bit                hold_off_req;

    fade_envelope_idle_timer dut (.*);

    always begin
        aclk = 1'b1;
        #CLK_HALF;
        aclk = 1'b0;
        #CLK_HALF;
    end

    // Trapezoid level for a music elapsed time
    function automatic logic [PEAK_W-1:0] fade_level(input logic [31:0] elapsed);
        longint unsigned e = 64'(elapsed);
        longint unsigned f = 64'(fade_ms);
        longint unsigned c = 64'(cycle_ms);
        longint unsigned p = 64'(peak_level);
        longint unsigned rest;
        if (e < f)
            return PEAK_W'((e * p) / f);
        if (e >= c)
            return '0;
        rest = c - e;
        if (rest >= f || f == 0)
            return PEAK_W'(p);
        return PEAK_W'((rest * p) / f);
    endfunction

    // Advance the tracked stamps by one transaction; return 1 when a result is due
    function automatic bit step_timer(input logic req, input logic [31:0] now,
                                      input logic act, output envelope_out_t out);
        logic [31:0] mus_ms;
        logic [31:0] idle_ms;
        out = '0;
        if (req == REQ_ENTER) begin
            music_stamp_ms = now;
            idle_stamp_ms  = now;
            return 1'b0;
        end
        if (act)
            idle_stamp_ms = now;
        mus_ms = now - music_stamp_ms;
        if (mus_ms >= cycle_ms) begin
            music_stamp_ms = now;
            mus_ms         = '0;
            out.restart    = 1'b1;
        end
        idle_ms     = now - idle_stamp_ms;
        out.attract = (idle_ms >= idle_limit_ms);
        out.volume  = fade_level(mus_ms);
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        if (mismatches < PRINT_CAP)
            $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Compare each result transaction with the oldest expectation
    always @(posedge aclk) begin
        envelope_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (envelope_due.size() == 0) begin
                report_mismatch("result with nothing expected", 64'(m_volume), 64'd0);
            end else begin
                want = envelope_due.pop_front();
                if (m_restart !== want.restart)
                    report_mismatch("restart flag", 64'(m_restart), 64'(want.restart));
                if (m_attract !== want.attract)
                    report_mismatch("attract flag", 64'(m_attract), 64'(want.attract));
                if (m_volume !== want.volume)
                    report_mismatch("volume", 64'(m_volume), 64'(want.volume));
            end
        end
    end

    // Stop a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Drive m_ready: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_OFF) @(negedge aclk);
            end
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Offer one transaction and record its expectation once accepted; call at a falling edge
    task automatic offer(input logic req, input logic [31:0] now, input logic act,
                         input bit typed, input envelope_out_t typed_out);
        envelope_out_t out;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_req_type      <= req;
        s_now_time      <= now;
        s_user_activity <= act;
        do @(posedge aclk); while (!s_ready);
        if (step_timer(req, now, act, out))
            envelope_due.push_back(typed ? typed_out : out);
        @(negedge aclk);
    endtask

    // Drop valid, wait for every result, then let any enter in flight finish
    task automatic quiesce();
        s_valid <= 1'b0;
        while (envelope_due.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic apb_xfer(input logic wr, input logic [1:0] idx, input logic [31:0] data,
                            output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic logic [31:0] reg_value(input logic [1:0] idx);
        case (idx)
            REG_FADE_TIME:    return 32'(fade_ms);
            REG_CYCLE_LENGTH: return cycle_ms;
            REG_IDLE_LIMIT:   return idle_limit_ms;
            REG_VOLUME_PEAK:  return 32'(peak_level);
            default:          return '0;
        endcase
    endfunction

    task automatic check_reg(input logic [1:0] idx);
        logic [31:0] rd;
        apb_xfer(1'b0, idx, '0, rd);
        if (rd !== reg_value(idx))
            report_mismatch($sformatf("register %0d readback", idx), 64'(rd),
                            64'(reg_value(idx)));
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        logic [31:0] ignored_rd;
        apb_xfer(1'b1, idx, data, ignored_rd);
        case (idx)
            REG_FADE_TIME:    fade_ms       = data[FADE_W-1:0];
            REG_CYCLE_LENGTH: cycle_ms      = data;
            REG_IDLE_LIMIT:   idle_limit_ms = data;
            REG_VOLUME_PEAK:  peak_level    = data[PEAK_W-1:0];
            default: ;
        endcase
        check_reg(idx);
    endtask

    initial begin
        plan_row_t     plan[$];
        envelope_out_t none;
        logic [31:0]   fade;
        logic [31:0]   cyc;
        logic [31:0]   lim;
        logic [31:0]   peak;
        logic [31:0]   noise;
        logic [31:0]   now_ms;
        int unsigned   step_max;
        bit            busy;

        none            = '0;
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_req_type      = REQ_ENTER;
        s_now_time      = '0;
        s_user_activity = 1'b0;
        m_ready         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        hold_off_req    = 1'b0;
        tx_idle_pct     = 15;
        rx_idle_pct     = 65;
        fade_ms         = RST_FADE_TIME;
        cycle_ms        = RST_CYCLE_LENGTH;
        idle_limit_ms   = RST_IDLE_LIMIT;
        peak_level      = RST_VOLUME_PEAK;
        music_stamp_ms  = '0;
        idle_stamp_ms   = '0;

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Register defaults after reset
        check_reg(REG_FADE_TIME);
        check_reg(REG_CYCLE_LENGTH);
        check_reg(REG_IDLE_LIMIT);
        check_reg(REG_VOLUME_PEAK);

        // Directed: reset settings, wrap-around, then the extremes of every register
        plan = '{
            '{ROW_ITEM, '0, 32'd0,          REQ_TICK,  1'b0, 1'b1, '{1'b0, 1'b0, 8'd0}},
            '{ROW_ITEM, '0, 32'd1000,       REQ_TICK,  1'b0, 1'b1, '{1'b0, 1'b0, 8'd3}},
            '{ROW_ITEM, '0, 32'd30000,      REQ_TICK,  1'b0, 1'b1, '{1'b0, 1'b1, 8'd7}},
            '{ROW_ITEM, '0, 32'd30000,      REQ_TICK,  1'b1, 1'b1, '{1'b0, 1'b0, 8'd7}},
            '{ROW_ITEM, '0, 32'd59000,      REQ_TICK,  1'b0, 1'b1, '{1'b0, 1'b0, 8'd3}},
            '{ROW_ITEM, '0, 32'd60000,      REQ_TICK,  1'b0, 1'b1, '{1'b1, 1'b1, 8'd0}},
            '{ROW_ITEM, '0, 32'hFFFF_FF00,  REQ_ENTER, 1'b1, 1'b0, '0},
            '{ROW_ITEM, '0, 32'h0000_0100,  REQ_TICK,  1'b0, 1'b1, '{1'b0, 1'b0, 8'd1}},
            '{ROW_ITEM, '0, 32'hFFFF_FFFF,  REQ_TICK,  1'b1, 1'b1, '{1'b0, 1'b0, 8'd0}},
            '{ROW_CFG, REG_FADE_TIME,    32'd0,         REQ_TICK, 1'b0, 1'b0, '0},
            '{ROW_CFG, REG_CYCLE_LENGTH, 32'd0,         REQ_TICK, 1'b0, 1'b0, '0},
            '{ROW_CFG, REG_IDLE_LIMIT,   32'd0,         REQ_TICK, 1'b0, 1'b0, '0},
            '{ROW_CFG, REG_VOLUME_PEAK,  32'd255,       REQ_TICK, 1'b0, 1'b0, '0},
            '{ROW_ITEM, '0, 32'd1234,       REQ_TICK,  1'b0, 1'b1, '{1'b1, 1'b1, 8'd0}},
            '{ROW_CFG, REG_CYCLE_LENGTH, 32'hFFFF_FFFF, REQ_TICK, 1'b0, 1'b0, '0},
            '{ROW_ITEM, '0, 32'd0,          REQ_ENTER, 1'b0, 1'b0, '0},
            '{ROW_ITEM, '0, 32'd5,          REQ_TICK,  1'b0, 1'b1, '{1'b0, 1'b1, 8'd255}},
            '{ROW_ITEM, '0, 32'hFFFF_FFFE,  REQ_TICK,  1'b0, 1'b1, '{1'b0, 1'b1, 8'd255}},
            '{ROW_ITEM, '0, 32'hFFFF_FFFF,  REQ_TICK,  1'b0, 1'b1, '{1'b1, 1'b1, 8'd255}},
            '{ROW_CFG, REG_FADE_TIME,    32'hABCD_FFFF, REQ_TICK, 1'b0, 1'b0, '0},
            '{ROW_CFG, REG_IDLE_LIMIT,   32'hFFFF_FFFF, REQ_TICK, 1'b0, 1'b0, '0},
            '{ROW_ITEM, '0, 32'd0,          REQ_ENTER, 1'b0, 1'b0, '0},
            '{ROW_ITEM, '0, 32'd65534,      REQ_TICK,  1'b0, 1'b1, '{1'b0, 1'b0, 8'd254}},
            '{ROW_ITEM, '0, 32'hFFFF_FFFE,  REQ_TICK,  1'b0, 1'b1, '{1'b0, 1'b0, 8'd0}},
            '{ROW_ITEM, '0, 32'hFFFF_FFFF,  REQ_TICK,  1'b0, 1'b1, '{1'b1, 1'b1, 8'd0}},
            '{ROW_CFG, REG_VOLUME_PEAK,  32'h0000_1200, REQ_TICK, 1'b0, 1'b0, '0},
            '{ROW_ITEM, '0, 32'd100,        REQ_TICK,  1'b1, 1'b1, '{1'b0, 1'b0, 8'd0}},
            '{ROW_CFG, REG_FADE_TIME,    32'd1,         REQ_TICK, 1'b0, 1'b0, '0},
            '{ROW_CFG, REG_VOLUME_PEAK,  32'd200,       REQ_TICK, 1'b0, 1'b0, '0},
            '{ROW_CFG, REG_CYCLE_LENGTH, 32'd1000,      REQ_TICK, 1'b0, 1'b0, '0},
            '{ROW_CFG, REG_IDLE_LIMIT,   32'd50,        REQ_TICK, 1'b0, 1'b0, '0},
            '{ROW_ITEM, '0, 32'd150,        REQ_TICK,  1'b0, 1'b0, '0},
            '{ROW_ITEM, '0, 32'd1149,       REQ_TICK,  1'b0, 1'b0, '0}
        };

        busy = 1'b1;
        foreach (plan[r]) begin
            if (plan[r].kind == ROW_CFG) begin
                if (busy)
                    quiesce();
                busy = 1'b0;
                write_reg(plan[r].reg_idx, plan[r].value);
            end else begin
                offer(plan[r].req, plan[r].value, plan[r].act, plan[r].typed, plan[r].want);
                busy = 1'b1;
            end
        end

        // Random phases: new settings each phase, time advancing in steps scaled to the longer of cycle and fade
        for (int p = 0; p < PHASES; p++) begin
            tx_idle_pct = (p < 2) ? 15 : (p < 4) ? 65 : 0;
            rx_idle_pct = (p < 2) ? 65 : (p < 4) ? 15 : 0;
            quiesce();

            noise = $urandom;
            case ($urandom_range(5))
                0:       fade = 32'd0;
                1:       fade = 32'd1;
                2:       fade = 32'hFFFF;
                default: fade = $urandom_range(2, 300);
            endcase
            case ($urandom_range(7))
                0:       cyc = 32'd0;
                1:       cyc = 32'hFFFF_FFFF;
                2:       cyc = $urandom_range(1, fade + 1);
                default: cyc = 2 * fade + $urandom_range(0, 600);
            endcase
            case ($urandom_range(5))
                0:       lim = 32'd0;
                1:       lim = 32'hFFFF_FFFF;
                default: lim = $urandom_range(0, 3000);
            endcase
            case ($urandom_range(5))
                0:       peak = 32'd0;
                1:       peak = 32'd255;
                default: peak = $urandom_range(1, 254);
            endcase
            write_reg(REG_FADE_TIME, {noise[31:16], fade[15:0]});
            write_reg(REG_CYCLE_LENGTH, cyc);
            write_reg(REG_IDLE_LIMIT, lim);
            write_reg(REG_VOLUME_PEAK, {noise[23:0], peak[7:0]});

            step_max = (cyc > fade) ? cyc : fade;
            if (step_max > 200000)
                step_max = 200000;
            step_max = step_max / 5 + 1;

            // Fill the block while the receiver holds off
            if (p == 0)
                hold_off_req = 1'b1;

            now_ms = $urandom_range(1) ? $urandom : 32'hFFFF_FFFF - $urandom_range(0, 4000);
            offer(REQ_ENTER, now_ms, 1'b0, 1'b0, none);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if ($urandom_range(49) == 0)
                    now_ms = $urandom;
                else
                    now_ms += $urandom_range(0, step_max);
                if ($urandom_range(19) == 0)
                    offer(REQ_ENTER, now_ms, 1'($urandom_range(1)), 1'b0, none);
                else
                    offer(REQ_TICK, now_ms, ($urandom_range(6) == 0), 1'b0, none);
            end
        end

        quiesce();
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
